// File: design/arpb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package arpb_pkg;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_START_REC  = 3'd1,
    CMD_STOP_REC   = 3'd2,
    CMD_START_PLAY = 3'd3,
    CMD_STOP_PLAY  = 3'd4,
    CMD_CLEAR      = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_START_REC,
    OP_STOP_REC,
    OP_START_PLAY,
    OP_STOP_PLAY,
    OP_CLEAR,
    OP_NOP
  } op_e;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_REC  = 2'd1,
    MODE_PLAY = 2'd2
  } mode_e;

  localparam logic [1:0] CFG_GAIN = 2'd0;
  localparam logic [1:0] CFG_GATE = 2'd1;

  localparam int unsigned MID_DEPTH = 2;
  localparam int unsigned OUT_DEPTH = 4;
  localparam int unsigned OCNT_W    = $clog2(OUT_DEPTH + 1);

  typedef struct packed {
    logic [2:0]  cmd;
    logic [11:0] adc_sample;
  } in_t;

  typedef struct packed {
    logic [9:0]  pwm_level;
    logic        pin_driven;
    logic [1:0]  mode;
    logic [15:0] stored_count;
    logic [8:0]  peak_magnitude;
    logic        command_ok;
    logic        record_done;
    logic        play_done;
  } out_t;

  // Classified item handed from the front to the back.
  typedef struct packed {
    op_e        op;
    logic [7:0] sample;
    logic [8:0] mag;
    logic       mag_ok;
  } mid_t;

endpackage
`default_nettype wire

// File: design/audio_record_playback_buffer.sv
// Audio record / playback buffer.
// Input queue side: drive item_i and raise push; the item is taken on a clock
// edge with push high and full low. Commands are tick, start/stop record,
// start/stop play and clear; a tick samples the converter while recording
// and advances the PWM level while playing.
// Result queue side: while empty is low, result_o shows the oldest result
// (state after its command); raise pop to take it. One result per item.
// Configuration: gain and gate threshold, written through cfg_valid_i /
// cfg_ready_o with cfg_index_i selecting the register; write only when idle.
// Path: stage register, middle queue, snapshot register, result queue.
// Throughput: one item per cycle while pop keeps up; the store has one write
// and one registered read port, one access per item, and the back end issues
// only while the four-entry result queue has room for every item in flight.
// When pop stays low, the result queue fills, the back end holds, the
// two-entry middle queue fills and full rises; nothing is dropped.
// Reset clears mode, counters, flags and queues; the level resets to 511 and
// the blend history to 512. The sample store is not cleared and needs no
// sweep: only entries written since the last start record are ever read.
`timescale 1ns / 1ps
`default_nettype none
module audio_record_playback_buffer
  import arpb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 32768
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire in_t        item_i,
  output logic            empty,
  input  wire logic       pop,
  output out_t            result_o,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [9:0] cfg_data_i
);
  logic              mid_push, mid_full, mid_pop, mid_empty;
  mid_t              mid_in, mid_out;
  logic              res_push;
  out_t              res_data;
  logic [OCNT_W-1:0] out_count;

  arpb_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .mid_push_o  (mid_push),
    .mid_item_o  (mid_in),
    .mid_full_i  (mid_full)
  );

  arpb_fifo #(.DEPTH(MID_DEPTH), .T(mid_t)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  (mid_in),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_out),
    .empty_o (mid_empty),
    .count_o ()
  );

  arpb_back #(.STORE_DEPTH(STORE_DEPTH)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .mid_empty_i (mid_empty),
    .mid_item_i  (mid_out),
    .mid_pop_o   (mid_pop),
    .out_count_i (out_count),
    .res_push_o  (res_push),
    .res_data_o  (res_data)
  );

  arpb_fifo #(.DEPTH(OUT_DEPTH), .T(out_t)) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (res_data),
    .full_o  (),
    .pop_i   (pop),
    .data_o  (result_o),
    .empty_o (empty),
    .count_o (out_count)
  );

endmodule
`default_nettype wire

// File: design/arpb_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
module arpb_fifo #(
  parameter int unsigned DEPTH = 2,
  parameter type T = logic
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push_i,
  input  wire T                             data_i,
  output logic                              full_o,
  input  wire logic                         pop_i,
  output T                                  data_o,
  output logic                              empty_o,
  output logic [$clog2(DEPTH + 1)-1:0]      count_o
);
  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  T              mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// File: design/arpb_front.sv
`timescale 1ns / 1ps
`default_nettype none
module arpb_front
  import arpb_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire in_t        item_i,
  input  wire logic       cfg_valid_i,
  output logic            cfg_ready_o,
  input  wire logic [1:0] cfg_index_i,
  input  wire logic [9:0] cfg_data_i,
  output logic            mid_push_o,
  output mid_t            mid_item_o,
  input  wire logic       mid_full_i
);
  logic [6:0]         gain_q;
  logic [9:0]         thr_q;
  logic               stg_valid_q, stg_valid_d;
  mid_t               stg_q, stg_d;
  logic               accept;
  logic signed [12:0] cen;
  logic signed [19:0] prod, gated, thr_s;
  logic signed [9:0]  clip;
  logic [9:0]         mag;

  assign cfg_ready_o = 1'b1;
  assign full        = stg_valid_q && mid_full_i;
  assign accept      = push && !full;
  assign mid_push_o  = stg_valid_q;
  assign mid_item_o  = stg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= 7'd8;
      thr_q  <= 10'd50;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == CFG_GAIN) begin
        gain_q <= cfg_data_i[6:0];
      end else if (cfg_index_i == CFG_GATE) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // Center, amplify, gate and clip the converter value.
  always_comb begin
    cen   = $signed({1'b0, item_i.adc_sample}) - 13'sd2048;
    prod  = 20'(cen) * $signed({13'b0, gain_q});
    thr_s = $signed({10'b0, thr_q});
    gated = (prod > -thr_s && prod < thr_s) ? 20'sd0 : prod;
    if (gated > 20'sd511) begin
      clip = 10'sd511;
    end else if (gated < -20'sd512) begin
      clip = -10'sd512;
    end else begin
      clip = gated[9:0];
    end
    mag = clip[9] ? 10'(-clip) : 10'(clip);
  end

  always_comb begin
    stg_d.sample = {~clip[9], clip[8:2]};
    stg_d.mag    = mag[8:0];
    stg_d.mag_ok = (mag < 10'd500);
    unique case (cmd_e'(item_i.cmd))
      CMD_TICK:       stg_d.op = OP_TICK;
      CMD_START_REC:  stg_d.op = OP_START_REC;
      CMD_STOP_REC:   stg_d.op = OP_STOP_REC;
      CMD_START_PLAY: stg_d.op = OP_START_PLAY;
      CMD_STOP_PLAY:  stg_d.op = OP_STOP_PLAY;
      CMD_CLEAR:      stg_d.op = OP_CLEAR;
      default:        stg_d.op = OP_NOP;
    endcase
  end

  always_comb begin
    stg_valid_d = stg_valid_q;
    if (accept) begin
      stg_valid_d = 1'b1;
    end else if (mid_push_o && !mid_full_i) begin
      stg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stg_valid_q <= 1'b0;
    end else begin
      stg_valid_q <= stg_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      stg_q <= stg_d;
    end
  end

endmodule
`default_nettype wire

// File: design/arpb_back.sv
`timescale 1ns / 1ps
`default_nettype none
module arpb_back
  import arpb_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 32768
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              mid_empty_i,
  input  wire mid_t              mid_item_i,
  output logic                   mid_pop_o,
  input  wire logic [OCNT_W-1:0] out_count_i,
  output logic                   res_push_o,
  output out_t                   res_data_o
);
  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(STORE_DEPTH);

  typedef enum logic [1:0] {LV_KEEP, LV_511, LV_512, LV_MEM} lvl_e;

  typedef struct packed {
    lvl_e        lvl;
    logic        pin_driven;
    logic [1:0]  mode;
    logic [15:0] stored_count;
    logic [8:0]  peak_magnitude;
    logic        command_ok;
    logic        record_done;
    logic        play_done;
  } snap_t;

  logic [7:0]    store [STORE_DEPTH];
  logic [7:0]    rd_data_q;

  mode_e         mode_q, mode_d;
  logic [CW-1:0] cnt_q, cnt_d, pos_q, pos_d;
  logic [8:0]    peak_q, peak_d;
  logic          drive_q, drive_d, rec_done_q, rec_done_d, play_done_q, play_done_d;
  logic          issue, ok, wr_en, rd_en;
  lvl_e          lvl;

  logic          b2_valid_q;
  snap_t         b2_q, b2_d;
  logic [9:0]    level_q, level_new, prev_q, s10;
  logic [10:0]   sum;

  // Issue only when the result queue has room for everything in flight.
  assign issue     = !mid_empty_i &&
                     ({1'b0, out_count_i} + (OCNT_W + 1)'(b2_valid_q) < (OCNT_W + 1)'(OUT_DEPTH));
  assign mid_pop_o = issue;

  always_comb begin
    mode_d      = mode_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    peak_d      = peak_q;
    drive_d     = drive_q;
    rec_done_d  = rec_done_q;
    play_done_d = play_done_q;
    ok          = 1'b0;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    lvl         = LV_KEEP;
    if (issue) begin
      unique case (mid_item_i.op)
        OP_TICK: begin
          if (mode_q == MODE_REC) begin
            if (cnt_q >= DEPTH_C) begin
              mode_d     = MODE_IDLE;
              rec_done_d = 1'b1;
            end else begin
              wr_en = 1'b1;
              cnt_d = cnt_q + CW'(1);
              if (mid_item_i.mag_ok && mid_item_i.mag > peak_q) begin
                peak_d = mid_item_i.mag;
              end
            end
          end else if (mode_q == MODE_PLAY) begin
            if (pos_q < cnt_q) begin
              rd_en = 1'b1;
              pos_d = pos_q + CW'(1);
              lvl   = LV_MEM;
            end else begin
              lvl         = LV_512;
              mode_d      = MODE_IDLE;
              play_done_d = 1'b1;
              drive_d     = 1'b0;
            end
          end
        end
        OP_START_REC: begin
          if (mode_q == MODE_IDLE) begin
            cnt_d      = '0;
            mode_d     = MODE_REC;
            rec_done_d = 1'b0;
            ok         = 1'b1;
          end
        end
        OP_STOP_REC: begin
          if (mode_q == MODE_REC) begin
            mode_d     = MODE_IDLE;
            rec_done_d = 1'b1;
          end
        end
        OP_START_PLAY: begin
          if (mode_q == MODE_IDLE && cnt_q != '0) begin
            drive_d     = 1'b1;
            lvl         = LV_511;
            mode_d      = MODE_PLAY;
            play_done_d = 1'b0;
            pos_d       = '0;
            ok          = 1'b1;
          end
        end
        OP_STOP_PLAY: begin
          if (mode_q == MODE_PLAY) begin
            lvl         = LV_511;
            mode_d      = MODE_IDLE;
            play_done_d = 1'b1;
            drive_d     = 1'b0;
          end
        end
        OP_CLEAR: begin
          if (mode_q == MODE_IDLE) begin
            cnt_d       = '0;
            rec_done_d  = 1'b0;
            play_done_d = 1'b0;
            peak_d      = '0;
          end
        end
        default: begin
        end
      endcase
    end
    b2_d.lvl            = lvl;
    b2_d.pin_driven     = drive_d;
    b2_d.mode           = mode_d;
    b2_d.stored_count   = 16'(cnt_d);
    b2_d.peak_magnitude = peak_d;
    b2_d.command_ok     = ok;
    b2_d.record_done    = rec_done_d;
    b2_d.play_done      = play_done_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_IDLE;
      cnt_q       <= '0;
      pos_q       <= '0;
      peak_q      <= '0;
      drive_q     <= 1'b0;
      rec_done_q  <= 1'b0;
      play_done_q <= 1'b0;
      b2_valid_q  <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      pos_q       <= pos_d;
      peak_q      <= peak_d;
      drive_q     <= drive_d;
      rec_done_q  <= rec_done_d;
      play_done_q <= play_done_d;
      b2_valid_q  <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      b2_q <= b2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store[cnt_q[AW-1:0]] <= mid_item_i.sample;
    end
    if (rd_en) begin
      rd_data_q <= store[pos_q[AW-1:0]];
    end
  end

  // Level stage: hold the level, load 511 or 512, or blend the fetched sample with the previous one.
  always_comb begin
    s10 = {rd_data_q, 2'b00};
    sum = {1'b0, prev_q} + {1'b0, s10};
    unique case (b2_q.lvl)
      LV_KEEP: level_new = level_q;
      LV_511:  level_new = 10'd511;
      LV_512:  level_new = 10'd512;
      LV_MEM:  level_new = sum[10:1];
      default: level_new = level_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      level_q <= 10'd511;
      prev_q  <= 10'd512;
    end else if (b2_valid_q) begin
      level_q <= level_new;
      if (b2_q.lvl == LV_MEM) begin
        prev_q <= s10;
      end
    end
  end

  assign res_push_o                = b2_valid_q;
  assign res_data_o.pwm_level      = level_new;
  assign res_data_o.pin_driven     = b2_q.pin_driven;
  assign res_data_o.mode           = b2_q.mode;
  assign res_data_o.stored_count   = b2_q.stored_count;
  assign res_data_o.peak_magnitude = b2_q.peak_magnitude;
  assign res_data_o.command_ok     = b2_q.command_ok;
  assign res_data_o.record_done    = b2_q.record_done;
  assign res_data_o.play_done      = b2_q.play_done;

endmodule
`default_nettype wire

// File: design/arpb_checker.sv
`timescale 1ns / 1ps
`default_nettype none
module arpb_checker
  import arpb_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic pop,
  input wire logic empty,
  input wire out_t result_o
);
  out_t prev_q;
  logic seen_q;
  logic take;

  assign take = pop && !empty;

  // Hold the last result taken to compare against the next one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q <= 1'b0;
    end else if (take) begin
      seen_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prev_q <= result_o;
    end
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(result_o)))
    else $error("waiting result changed or vanished");

  a_peak_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && seen_q && result_o.peak_magnitude < prev_q.peak_magnitude)
      |-> (prev_q.mode == MODE_IDLE))
    else $error("peak dropped outside idle");

  a_enter_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && seen_q && result_o.mode != prev_q.mode &&
     (result_o.mode == MODE_REC || result_o.mode == MODE_PLAY))
      |-> result_o.command_ok)
    else $error("mode entered without accepted start");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && seen_q && prev_q.mode == MODE_REC && result_o.mode == MODE_REC)
      |-> (16'(result_o.stored_count - prev_q.stored_count) == 16'd0 ||
           16'(result_o.stored_count - prev_q.stored_count) == 16'd1))
    else $error("stored count jumped while recording");

endmodule

bind audio_record_playback_buffer arpb_checker u_arpb_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .pop      (pop),
  .empty    (empty),
  .result_o (result_o)
);
`default_nettype wire
